// ===== hdl/mstimer_pkg.sv =====
`default_nettype none

package mstimer_pkg;

   // Default number of timestamp slots, slot 0 being the running clock.
   localparam int MST_NUM_SLOTS = 9;

   localparam int MST_TPS_W = 16;
   localparam int MST_MIN_W = 7;
   localparam int MST_SEC_W = 6;
   localparam int MST_CHAR_W = 7;

   localparam logic [MST_TPS_W-1:0] MST_TPS_RESET = 16'd1000;
   localparam logic [MST_MIN_W-1:0] MST_MAX_MIN = 7'd99;
   localparam logic [MST_SEC_W-1:0] MST_MAX_SEC = 6'd59;
   localparam logic [MST_CHAR_W-1:0] MST_CHAR_ZERO = 7'h30;
   localparam logic [MST_CHAR_W-1:0] MST_CHAR_COLON = 7'h3A;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_DISPLAY = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      SEL_MIN_TENS = 3'd0,
      SEL_MIN_ONES = 3'd1,
      SEL_COLON = 3'd2,
      SEL_SEC_TENS = 3'd3,
      SEL_SEC_ONES = 3'd4
   } char_sel_type;

   // Each waiting state names the character that is loaded next.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIN_ONES,
      ST_COLON,
      ST_SEC_TENS,
      ST_SEC_ONES
   } state_type;

   typedef struct packed {
      logic exec;
      logic load_char;
      char_sel_type char_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic display_ok;
      logic out_full;
   } dp_status_type;

   // Tens digit of a value below 100, found with independent compares.
   function automatic logic [3:0] tens_digit(input logic [MST_MIN_W-1:0] v);
      logic [3:0] t;
      t = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (v >= 7'(10 * i)) begin
            t = 4'(i);
         end
      end
      return t;
   endfunction

   function automatic logic [3:0] ones_digit(input logic [MST_MIN_W-1:0] v);
      logic [3:0] t;
      logic [MST_MIN_W-1:0] r;
      t = tens_digit(v);
      r = v - (7'(t) * 7'd10);
      return r[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/mstimer_ctrl.sv =====
`default_nettype none

module mstimer_ctrl
   import mstimer_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;
   logic out_free;

   // The output register can take a new word when empty or emptied now.
   assign out_free = !status.out_full || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free && status.display_ok) begin
               state_in = ST_MIN_ONES;
            end
         end
         ST_MIN_ONES: if (out_free) state_in = ST_COLON;
         ST_COLON:    if (out_free) state_in = ST_SEC_TENS;
         ST_SEC_TENS: if (out_free) state_in = ST_SEC_ONES;
         ST_SEC_ONES: if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.exec = 1'b0;
      cmd.load_char = 1'b0;
      cmd.char_sel = SEL_MIN_TENS;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            cmd.exec = req_valid && out_free;
         end
         ST_MIN_ONES: begin
            cmd.load_char = out_free;
            cmd.char_sel = SEL_MIN_ONES;
         end
         ST_COLON: begin
            cmd.load_char = out_free;
            cmd.char_sel = SEL_COLON;
         end
         ST_SEC_TENS: begin
            cmd.load_char = out_free;
            cmd.char_sel = SEL_SEC_TENS;
         end
         ST_SEC_ONES: begin
            cmd.load_char = out_free;
            cmd.char_sel = SEL_SEC_ONES;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/mstimer_dp.sv =====
`default_nettype none

module mstimer_dp
   import mstimer_pkg::*;
#(
   parameter int NUM_SLOTS = MST_NUM_SLOTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [MST_TPS_W-1:0]  csr_data,
   input  wire logic [1:0]            req_command,
   input  wire logic [3:0]            req_slot,
   input  wire logic [MST_MIN_W-1:0]  req_new_minutes,
   input  wire logic [MST_SEC_W-1:0]  req_new_seconds,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [MST_CHAR_W-1:0]      rsp_char_code,
   output logic                       rsp_char_valid,
   output logic                       rsp_last,
   output logic [MST_MIN_W-1:0]       rsp_clock_minutes,
   output logic [MST_SEC_W-1:0]       rsp_clock_seconds
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [MST_TPS_W-1:0] tps_ff;
   logic [MST_TPS_W-1:0] cnt_ff;
   logic [MST_TPS_W-1:0] cnt_in;
   logic [MST_TPS_W-1:0] cnt_inc;
   logic [MST_MIN_W-1:0] min_ff [NUM_SLOTS];
   logic [MST_MIN_W-1:0] min_in [NUM_SLOTS];
   logic [MST_SEC_W-1:0] sec_ff [NUM_SLOTS];
   logic [MST_SEC_W-1:0] sec_in [NUM_SLOTS];
   logic [IDX_W-1:0]     slot_ff;
   logic [IDX_W-1:0]     req_idx;
   logic [IDX_W-1:0]     disp_idx;
   logic                 slot_ok;
   logic [MST_MIN_W-1:0] sat_min;
   logic [MST_SEC_W-1:0] sat_sec;
   logic [MST_MIN_W-1:0] disp_min;
   logic [MST_SEC_W-1:0] disp_sec;
   char_sel_type         sel;
   logic [3:0]           digit;
   logic [MST_CHAR_W-1:0] char_val;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [MST_CHAR_W-1:0] char_ff;
   logic                  char_valid_ff;
   logic                  last_ff;
   logic [MST_MIN_W-1:0]  clk_min_ff;
   logic [MST_SEC_W-1:0]  clk_sec_ff;

   assign req_idx = req_slot[IDX_W-1:0];
   assign slot_ok = {1'b0, req_slot} < 5'(NUM_SLOTS);
   assign sat_min = (req_new_minutes > MST_MAX_MIN) ? MST_MAX_MIN : req_new_minutes;
   assign sat_sec = (req_new_seconds > MST_MAX_SEC) ? MST_MAX_SEC : req_new_seconds;
   assign cnt_inc = cnt_ff + 16'd1;

   assign status.display_ok = (cmd_type'(req_command) == CMD_DISPLAY) && slot_ok;
   assign status.out_full = rsp_valid_ff;

   // Next value of the tick counter and of the timestamp table.
   always_comb begin
      cnt_in = cnt_ff;
      min_in = min_ff;
      sec_in = sec_ff;
      if (cmd.exec) begin
         unique case (cmd_type'(req_command))
            CMD_TICK: begin
               if (cnt_inc >= tps_ff) begin
                  cnt_in = '0;
                  if (sec_ff[0] >= MST_MAX_SEC) begin
                     sec_in[0] = '0;
                     min_in[0] = (min_ff[0] >= MST_MAX_MIN) ? '0 : min_ff[0] + 7'd1;
                  end else begin
                     sec_in[0] = sec_ff[0] + 6'd1;
                  end
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            CMD_WRITE: begin
               if (slot_ok) begin
                  min_in[req_idx] = sat_min;
                  sec_in[req_idx] = sat_sec;
                  cnt_in = '0;
               end
            end
            CMD_DISPLAY, CMD_NONE: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
   end

   // The slot being shown is read from the request at acceptance and from
   // the latched slot while the remaining characters go out.
   assign disp_idx = cmd.exec ? req_idx : slot_ff;

   always_comb begin
      disp_min = '0;
      disp_sec = '0;
      if ({1'b0, disp_idx} < (IDX_W + 1)'(NUM_SLOTS)) begin
         disp_min = min_ff[disp_idx];
         disp_sec = sec_ff[disp_idx];
      end
   end

   assign sel = cmd.exec ? SEL_MIN_TENS : cmd.char_sel;

   always_comb begin
      digit = 4'd0;
      char_val = MST_CHAR_COLON;
      unique case (sel)
         SEL_MIN_TENS: digit = tens_digit(disp_min);
         SEL_MIN_ONES: digit = ones_digit(disp_min);
         SEL_SEC_TENS: digit = tens_digit({1'b0, disp_sec});
         SEL_SEC_ONES: digit = ones_digit({1'b0, disp_sec});
         default:      digit = 4'd0;
      endcase
      if (sel != SEL_COLON) begin
         char_val = MST_CHAR_ZERO + {3'b000, digit};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec || cmd.load_char) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= MST_TPS_RESET;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            min_ff[i] <= '0;
            sec_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            tps_ff <= csr_data;
         end
         cnt_ff <= cnt_in;
         min_ff <= min_in;
         sec_ff <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         slot_ff <= req_idx;
         clk_min_ff <= min_in[0];
         clk_sec_ff <= sec_in[0];
         if (status.display_ok) begin
            char_ff <= char_val;
            char_valid_ff <= 1'b1;
            last_ff <= 1'b0;
         end else begin
            char_ff <= '0;
            char_valid_ff <= 1'b0;
            last_ff <= 1'b1;
         end
      end else if (cmd.load_char) begin
         char_ff <= char_val;
         char_valid_ff <= 1'b1;
         last_ff <= (cmd.char_sel == SEL_SEC_ONES);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_char_valid = char_valid_ff;
   assign rsp_last = last_ff;
   assign rsp_clock_minutes = clk_min_ff;
   assign rsp_clock_seconds = clk_sec_ff;

endmodule

`default_nettype wire

// ===== hdl/minute_second_timer_with_display.sv =====
// Minute:second timer with an ASCII MM:SS display of its timestamp slots.
// Request words carry a command (tick, write timestamp, display slot), a slot
// and the minutes and seconds for a write. Every request gives one response
// word, except a display of an existing slot, which gives five words: two
// minute digits, a colon and two second digits, with last set on the fifth.
// Every response word also reports the running clock (slot 0) after the step.
// The csr channel writes ticks_per_second; it is always ready and should be
// used only while no request is in flight.
// A response word is loaded into the output register when its request is
// accepted. Tick, write and ignored requests sustain one per cycle while the
// receiver keeps rsp_ready high. A display holds the request side while the
// controller steps through the remaining characters, one word at a time.
// When the receiver stalls, the output register holds its word and the next
// request or character waits until that word is taken.
// Synchronous reset clears the tick count and every timestamp slot at once
// and sets ticks_per_second to 1000.
`default_nettype none

module minute_second_timer_with_display
   import mstimer_pkg::*;
#(
   parameter int NUM_SLOTS = MST_NUM_SLOTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [MST_TPS_W-1:0]  csr_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_command,
   input  wire logic [3:0]            req_slot,
   input  wire logic [MST_MIN_W-1:0]  req_new_minutes,
   input  wire logic [MST_SEC_W-1:0]  req_new_seconds,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [MST_CHAR_W-1:0]      rsp_char_code,
   output logic                       rsp_char_valid,
   output logic                       rsp_last,
   output logic [MST_MIN_W-1:0]       rsp_clock_minutes,
   output logic [MST_SEC_W-1:0]       rsp_clock_seconds
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The register write completes in the cycle it is presented.
   assign csr_ready = 1'b1;

   // The controller sequences request acceptance and the display characters.
   mstimer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the counter, the timestamp slots and the output word.
   mstimer_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .req_command       (req_command),
      .req_slot          (req_slot),
      .req_new_minutes   (req_new_minutes),
      .req_new_seconds   (req_new_seconds),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_char_code     (rsp_char_code),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_last          (rsp_last),
      .rsp_clock_minutes (rsp_clock_minutes),
      .rsp_clock_seconds (rsp_clock_seconds)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

// Self-checking bench for the minute:second timer with its MM:SS display.
// A short scripted sequence runs first. It covers the displays right after
// reset, slots beyond the table, the ignored command, saturating writes, the
// 99:59 wrap, a zero ticks_per_second and a ticks_per_second lowered below the
// running count. After that, random request words run in phases, one phase
// per ticks_per_second setting. Every accepted request word goes through a
// local timer model. The model queues the response words that the block owes,
// and each accepted response word is checked against the oldest one queued.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mstimer_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 55;

   // One request word as the sender drives it.
   typedef struct packed {
      cmd_type        command;
      logic [3:0]     slot;
      logic [6:0]     nm;
      logic [5:0]     ns;
   } req_word_type;

   // One response word as the receiver sees it.
   typedef struct packed {
      logic [6:0]     char_code;
      logic           char_valid;
      logic           last;
      logic [6:0]     minutes;
      logic [5:0]     seconds;
   } rsp_word_type;

   // A script row either writes ticks_per_second or sends one request word.
   // The expected response of a word row is written into the row when it can
   // be seen at a glance. Otherwise the timer model works it out.
   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_BLANK, CHK_TEXT} row_check_type;

   typedef struct packed {
      row_kind_type   kind;
      row_check_type  check;
      cmd_type        command;
      logic [3:0]     slot;
      logic [6:0]     nm;
      logic [5:0]     ns;
      logic [15:0]    csr;
      logic [39:0]    text;
      logic [6:0]     mm;
      logic [5:0]     ss;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [MST_TPS_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = '0;
   logic [3:0] req_slot = '0;
   logic [MST_MIN_W-1:0] req_new_minutes = '0;
   logic [MST_SEC_W-1:0] req_new_seconds = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [MST_CHAR_W-1:0] rsp_char_code;
   logic rsp_char_valid;
   logic rsp_last;
   logic [MST_MIN_W-1:0] rsp_clock_minutes;
   logic [MST_SEC_W-1:0] rsp_clock_seconds;

   minute_second_timer_with_display dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_slot          (req_slot),
      .req_new_minutes   (req_new_minutes),
      .req_new_seconds   (req_new_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_code     (rsp_char_code),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_last          (rsp_last),
      .rsp_clock_minutes (rsp_clock_minutes),
      .rsp_clock_seconds (rsp_clock_seconds)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Timer model state: the configured rate, the tick count and the table of
   // timestamps, with slot 0 as the running clock.
   logic [15:0] tps_m;
   logic [15:0] tick_m;
   logic [6:0] min_m [MST_NUM_SLOTS];
   logic [5:0] sec_m [MST_NUM_SLOTS];

   // Response words owed by the block, oldest first.
   rsp_word_type rsp_due [$];

   row_type script [$];
   int errors = 0;
   int cycles = 0;

   function automatic void expect_word(input logic [6:0] code, input logic valid,
                                       input logic fin, input logic [6:0] mm,
                                       input logic [5:0] ss);
      rsp_word_type e;
      e.char_code = code;
      e.char_valid = valid;
      e.last = fin;
      e.minutes = mm;
      e.seconds = ss;
      rsp_due.push_back(e);
   endfunction

   // Applies one accepted request word to the timer model. When record is
   // set, the response words it causes are queued as well.
   function automatic void step_timer(input req_word_type w, input bit record);
      int m;
      int s;
      bit shown;
      m = 0;
      s = 0;
      shown = 1'b0;
      case (w.command)
         CMD_TICK: begin
            tick_m = tick_m + 16'd1;
            if (tick_m >= tps_m) begin
               tick_m = '0;
               if (sec_m[0] >= MST_MAX_SEC) begin
                  sec_m[0] = '0;
                  min_m[0] = (min_m[0] >= MST_MAX_MIN) ? 7'd0 : min_m[0] + 7'd1;
               end else begin
                  sec_m[0] = sec_m[0] + 6'd1;
               end
            end
         end
         CMD_WRITE: begin
            if (w.slot < MST_NUM_SLOTS) begin
               min_m[w.slot] = (w.nm > MST_MAX_MIN) ? MST_MAX_MIN : w.nm;
               sec_m[w.slot] = (w.ns > MST_MAX_SEC) ? MST_MAX_SEC : w.ns;
               tick_m = '0;
            end
         end
         CMD_DISPLAY: begin
            if (w.slot < MST_NUM_SLOTS) begin
               m = min_m[w.slot];
               s = sec_m[w.slot];
               shown = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!record) begin
         return;
      end
      if (shown) begin
         expect_word(MST_CHAR_ZERO + 7'(m / 10), 1'b1, 1'b0, min_m[0], sec_m[0]);
         expect_word(MST_CHAR_ZERO + 7'(m % 10), 1'b1, 1'b0, min_m[0], sec_m[0]);
         expect_word(MST_CHAR_COLON, 1'b1, 1'b0, min_m[0], sec_m[0]);
         expect_word(MST_CHAR_ZERO + 7'(s / 10), 1'b1, 1'b0, min_m[0], sec_m[0]);
         expect_word(MST_CHAR_ZERO + 7'(s % 10), 1'b1, 1'b1, min_m[0], sec_m[0]);
      end else begin
         expect_word('0, 1'b0, 1'b1, min_m[0], sec_m[0]);
      end
   endfunction

   function automatic row_type word_row(input row_check_type check, input cmd_type command,
                                        input logic [3:0] slot, input logic [6:0] nm,
                                        input logic [5:0] ns, input logic [39:0] text,
                                        input logic [6:0] mm, input logic [5:0] ss);
      row_type r;
      r = '0;
      r.kind = ROW_WORD;
      r.check = check;
      r.command = command;
      r.slot = slot;
      r.nm = nm;
      r.ns = ns;
      r.text = text;
      r.mm = mm;
      r.ss = ss;
      return r;
   endfunction

   function automatic row_type csr_row(input logic [15:0] value);
      row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.csr = value;
      return r;
   endfunction

   // Random request word. Most words are well formed. A few use slots beyond
   // the table, out-of-range times or the ignored command. Writes to the
   // running clock sometimes land just before 99:59 so that the minute wrap
   // is reached by ticking.
   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         w.command = CMD_TICK;
      end else if (pick < 70) begin
         w.command = CMD_WRITE;
      end else if (pick < 95) begin
         w.command = CMD_DISPLAY;
      end else begin
         w.command = CMD_NONE;
      end
      w.slot = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
      w.nm = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(100, 127))
                                          : 7'($urandom_range(0, 99));
      w.ns = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(60, 63))
                                          : 6'($urandom_range(0, 59));
      if (w.command == CMD_WRITE && w.slot == 4'd0 && $urandom_range(0, 3) == 0) begin
         w.nm = 7'd99;
         w.ns = 6'($urandom_range(55, 59));
      end
      return w;
   endfunction

   // Presents one request word and returns at the edge that accepts it.
   // The valid stays high when the caller sends the next word right away.
   task automatic drive_word(input req_word_type w);
      req_valid <= 1'b1;
      req_command <= w.command;
      req_slot <= w.slot;
      req_new_minutes <= w.nm;
      req_new_seconds <= w.ns;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Writes ticks_per_second once the block is idle. Every request word gives
   // at least one response word, so an empty queue means no request is in
   // flight; the short pause covers the output register.
   task automatic write_tps(input logic [15:0] value);
      while (rsp_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      tps_m = value;
   endtask

   // Sends random words in bursts with random gaps between them, until the
   // given number of words that the block does not just ignore has gone out.
   task automatic run_traffic(input int count);
      req_word_type w;
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         for (int i = 0; i < burst && sent < count; i++) begin
            w = random_word();
            drive_word(w);
            step_timer(w, 1'b1);
            if (!(w.command == CMD_NONE
                  || (w.command != CMD_TICK && w.slot >= MST_NUM_SLOTS))) begin
               sent++;
            end
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // The receiver stalls in its own pattern. It moves through four modes in
   // turn, set by the top bits of a free-running phase counter: always ready,
   // a coin toss, ready one cycle in four, and mostly ready.
   logic [7:0] stall_phase = '0;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      case (stall_phase[7:6])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (stall_phase[1:0] == 2'd0);
         default: rsp_ready <= ($urandom_range(0, 9) < 8);
      endcase
   end

   // Response checker. Each accepted response word must match the oldest
   // word that the timer model has queued.
   rsp_word_type got;
   rsp_word_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_char_code, rsp_char_valid, rsp_last, rsp_clock_minutes,
                rsp_clock_seconds};
         if (rsp_due.size() == 0) begin
            errors++;
            $display("%0t: response word with none expected:", $time,
                     " char=%h valid=%b last=%b clock=%0d:%0d",
                     got.char_code, got.char_valid, got.last, got.minutes,
                     got.seconds);
         end else begin
            want = rsp_due.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: response mismatch:", $time,
                        " expected char=%h valid=%b last=%b clock=%0d:%0d,",
                        want.char_code, want.char_valid, want.last, want.minutes,
                        want.seconds,
                        " actual char=%h valid=%b last=%b clock=%0d:%0d",
                        got.char_code, got.char_valid, got.last, got.minutes,
                        got.seconds);
            end
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      row_type r;
      req_word_type w;
      logic [15:0] phase_tps [8];

      tps_m = MST_TPS_RESET;
      tick_m = '0;
      for (int i = 0; i < MST_NUM_SLOTS; i++) begin
         min_m[i] = '0;
         sec_m[i] = '0;
      end

      // Right after reset every slot reads 00:00 and the rate is 1000.
      script.push_back(word_row(CHK_TEXT, CMD_DISPLAY, 4'd0, 7'd0, 6'd0, "00:00", 7'd0, 6'd0));
      script.push_back(word_row(CHK_TEXT, CMD_DISPLAY, 4'd8, 7'd0, 6'd0, "00:00", 7'd0, 6'd0));
      // A display beyond the table and the ignored command give one blank word.
      script.push_back(word_row(CHK_BLANK, CMD_DISPLAY, 4'd9, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_BLANK, CMD_NONE, 4'd15, 7'd127, 6'd63, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_BLANK, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_BLANK, CMD_WRITE, 4'd0, 7'd99, 6'd59, 40'd0, 7'd99, 6'd59));
      script.push_back(word_row(CHK_TEXT, CMD_DISPLAY, 4'd0, 7'd0, 6'd0, "99:59", 7'd99, 6'd59));
      // Out-of-range times saturate to 99:59.
      script.push_back(word_row(CHK_BLANK, CMD_WRITE, 4'd8, 7'd127, 6'd63, 40'd0, 7'd99, 6'd59));
      script.push_back(word_row(CHK_TEXT, CMD_DISPLAY, 4'd8, 7'd0, 6'd0, "99:59", 7'd99, 6'd59));
      script.push_back(word_row(CHK_BLANK, CMD_WRITE, 4'd15, 7'd0, 6'd0, 40'd0, 7'd99, 6'd59));
      script.push_back(word_row(CHK_BLANK, CMD_WRITE, 4'd5, 7'd100, 6'd60, 40'd0, 7'd99, 6'd59));
      script.push_back(word_row(CHK_MODEL, CMD_WRITE, 4'd3, 7'd42, 6'd7, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_TEXT, CMD_DISPLAY, 4'd3, 7'd0, 6'd0, "42:07", 7'd99, 6'd59));
      // One tick per second: 99:59 wraps to 00:00, then the seconds carry.
      script.push_back(csr_row(16'd1));
      script.push_back(word_row(CHK_BLANK, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_BLANK, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd1));
      script.push_back(word_row(CHK_MODEL, CMD_WRITE, 4'd0, 7'd12, 6'd59, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      // A rate of zero makes every tick a second.
      script.push_back(csr_row(16'd0));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      // A write beyond the table keeps the tick count. The rate is then
      // lowered below the count, so the next tick must advance the clock.
      script.push_back(csr_row(16'd10));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_MODEL, CMD_WRITE, 4'd12, 7'd1, 6'd1, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(csr_row(16'd4));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      // The largest rate.
      script.push_back(csr_row(16'd65535));
      script.push_back(word_row(CHK_MODEL, CMD_TICK, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));
      script.push_back(word_row(CHK_MODEL, CMD_DISPLAY, 4'd0, 7'd0, 6'd0, 40'd0, 7'd0, 6'd0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The scripted words go out back to back. Before each register write
      // the valid drops, and the write waits until the block has drained.
      foreach (script[i]) begin
         r = script[i];
         if (r.kind == ROW_CSR) begin
            req_valid <= 1'b0;
            write_tps(r.csr);
         end else begin
            w.command = r.command;
            w.slot = r.slot;
            w.nm = r.nm;
            w.ns = r.ns;
            drive_word(w);
            if (r.check == CHK_MODEL) begin
               step_timer(w, 1'b1);
            end else begin
               step_timer(w, 1'b0);
               if (r.check == CHK_TEXT) begin
                  for (int k = 0; k < 5; k++) begin
                     expect_word(r.text[8 * (4 - k) +: 7], 1'b1, (k == 4), r.mm, r.ss);
                  end
               end else begin
                  expect_word('0, 1'b0, 1'b1, r.mm, r.ss);
               end
            end
         end
      end
      req_valid <= 1'b0;

      // Random phases, one per rate. The sender pauses until the block has
      // drained before each rate change. Going from 65535 down to 1 lowers
      // the rate below whatever count has built up.
      phase_tps = '{16'd3, 16'd65535, 16'd1, 16'd0, 16'd2, 16'd7, 16'd1000, 16'd0};
      phase_tps[7] = 16'($urandom_range(1, 12));
      for (int p = 0; p < 8; p++) begin
         write_tps(phase_tps[p]);
         run_traffic(PHASE_WORDS);
      end

      while (rsp_due.size() != 0) begin
         @(posedge clock);
      end
      // Keep running past the drain, so that any extra response word is caught.
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/mstimer_pkg.sv
hdl/mstimer_ctrl.sv
hdl/mstimer_dp.sv
hdl/minute_second_timer_with_display.sv
tb/tb.sv
